// ----- sv/r2h_pkg.sv -----
package r2h_pkg;

  localparam int ChanW    = 8;
  localparam int HueW     = 15;
  localparam int SatW     = 16;
  localparam int SatFracW = 15;

  // hue in 1/64 degree: 60 degrees per sector unit, 360 degrees full turn
  localparam int HueScale = 60 * 64;
  localparam int HueFull  = 6 * HueScale;

  // divider, one instance each for hue and saturation: numerator = remainder seed (DenW bits) over QuoW shifted bits
  localparam int DenW        = ChanW;
  localparam int QuoW        = SatW;
  localparam int NumW        = DenW + QuoW;
  localparam int DivStages   = 4;
  localparam int BitsPerStg  = QuoW / DivStages;

  // input reg, sort, scale, divider stages, output reg
  localparam int PipeDepth   = 3 + DivStages + 1;

  typedef enum logic [1:0] {
    SecRed   = 2'd0,
    SecGreen = 2'd1,
    SecBlue  = 2'd2
  } sector_e;

  typedef struct packed {
    logic [ChanW-1:0] brightness;
    logic             gray;
    sector_e          sector;
    logic             neg;
  } side_t;

endpackage

// ----- sv/r2h_div.sv -----
module r2h_div (
  input  logic                     clk_i,
  input  logic [r2h_pkg::DivStages-1:0] en_i,
  input  logic [r2h_pkg::NumW-1:0] num_i,
  input  logic [r2h_pkg::DenW-1:0] den_i,
  output logic [r2h_pkg::QuoW-1:0] quo_o
);
  import r2h_pkg::*;

  // restoring divider, BitsPerStg quotient bits per stage; the top DenW bits
  // of the numerator must be below the divisor
  logic [DenW-1:0] rem_q [DivStages-1];
  logic [DenW-1:0] den_q [DivStages-1];
  logic [QuoW-1:0] num_q [DivStages-1];
  logic [QuoW-1:0] quo_q [DivStages];

  for (genvar j = 0; j < DivStages; j++) begin : g_stg
    logic [DenW-1:0] rem_in;
    logic [DenW-1:0] den_in;
    logic [QuoW-1:0] num_in;
    logic [QuoW-1:0] quo_in;
    logic [DenW-1:0] rem_d;
    logic [QuoW-1:0] num_d;
    logic [QuoW-1:0] quo_d;

    if (j == 0) begin : g_first
      assign rem_in = num_i[NumW-1 -: DenW];
      assign num_in = num_i[QuoW-1:0];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign num_in = num_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    always_comb begin
      logic [DenW:0] trial;
      rem_d = rem_in;
      num_d = num_in;
      quo_d = quo_in;
      for (int b = 0; b < BitsPerStg; b++) begin
        trial = {rem_d, num_d[QuoW-1]};
        num_d = {num_d[QuoW-2:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          trial = trial - {1'b0, den_in};
          quo_d = {quo_d[QuoW-2:0], 1'b1};
        end else begin
          quo_d = {quo_d[QuoW-2:0], 1'b0};
        end
        rem_d = trial[DenW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        quo_q[j] <= quo_d;
      end
    end

    if (j < DivStages - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i[j]) begin
          rem_q[j] <= rem_d;
          num_q[j] <= num_d;
          den_q[j] <= den_in;
        end
      end
    end else begin : g_last
      // nothing left to carry past the final quotient bits
      logic unused_rem;
      assign unused_rem = ^{rem_d, num_d};
    end
  end

  assign quo_o = quo_q[DivStages-1];

endmodule

// ----- sv/rgb_to_hsv_converter_top.sv -----
// RGB to HSV pixel converter.
// Input channel: valid_i / stall_o with red_i, green_i, blue_i. A pixel transfers
// on a rising edge with valid_i high and stall_o low.
// Output channel: valid_o / stall_i with hue_o (1/64 degree, 0..23039),
// saturation_o (Q1.15, 32768 = 1.0) and brightness_o (largest channel).
// Gray pixels give hue and saturation zero; ties pick red, then green, then blue.
// Throughput: one pixel per clock, sustained, with no stalls.
// The pipeline is an input register, a min/max/sector stage, a hue scaling
// multiply, four stages of restoring division (4 quotient bits each, hue and
// saturation side by side) and an output register.
// Stalls: each stage holds when it is full and the stage after it holds, so
// bubbles are squeezed out and stall_o rises only when every stage is full and
// stall_i is high. Nothing is dropped or repeated.
// Reset: rst_ni clears all valid bits; the pipeline comes up empty.
module rgb_to_hsv_converter_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic [r2h_pkg::ChanW-1:0]  red_i,
  input  logic [r2h_pkg::ChanW-1:0]  green_i,
  input  logic [r2h_pkg::ChanW-1:0]  blue_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output logic [r2h_pkg::HueW-1:0]   hue_o,
  output logic [r2h_pkg::SatW-1:0]   saturation_o,
  output logic [r2h_pkg::ChanW-1:0]  brightness_o
);
  import r2h_pkg::*;

  localparam int DivFirst = 3;
  localparam int OutStg   = PipeDepth - 1;

  logic [PipeDepth-1:0] v_q, v_d;
  logic [PipeDepth:0]   en;

  always_comb begin
    en[PipeDepth] = !stall_i;
    for (int k = PipeDepth - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign stall_o = !en[0];

  always_comb begin
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = valid_i;
    end
    for (int k = 1; k < PipeDepth; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // stage 0: input register
  logic [ChanW-1:0] r_q, g_q, b_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      r_q <= red_i;
      g_q <= green_i;
      b_q <= blue_i;
    end
  end

  // stage 1: max, min, sector and |diff|
  side_t            side1_d;
  logic [ChanW-1:0] delta_d, adiff_d;

  always_comb begin
    logic [ChanW-1:0] mx, mn;
    logic [ChanW:0]   diff;
    mx = (r_q > g_q) ? r_q : g_q;
    mx = (mx > b_q) ? mx : b_q;
    mn = (r_q < g_q) ? r_q : g_q;
    mn = (mn < b_q) ? mn : b_q;
    delta_d = mx - mn;
    if (r_q >= mx) begin
      side1_d.sector = SecRed;
      diff = {1'b0, g_q} - {1'b0, b_q};
    end else if (g_q >= mx) begin
      side1_d.sector = SecGreen;
      diff = {1'b0, b_q} - {1'b0, r_q};
    end else begin
      side1_d.sector = SecBlue;
      diff = {1'b0, r_q} - {1'b0, g_q};
    end
    side1_d.neg        = diff[ChanW];
    adiff_d            = diff[ChanW] ? ChanW'(-diff) : diff[ChanW-1:0];
    side1_d.brightness = mx;
    side1_d.gray       = (delta_d == '0);
  end

  side_t            side_q [1:OutStg-1];
  logic [ChanW-1:0] delta_q, adiff_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      side_q[1] <= side1_d;
      delta_q   <= delta_d;
      adiff_q   <= adiff_d;
    end
    for (int k = 2; k < OutStg; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // stage 2: numerators for both dividers
  logic [NumW-1:0] num_h_d;
  logic [NumW-1:0] num_h_q, num_s_q;
  logic [DenW-1:0] den_h_q, den_s_q;

  always_comb begin
    num_h_d = NumW'(adiff_q) * NumW'(HueScale);
    // offset minus a negative difference must still truncate toward zero,
    // so that quotient rounds up
    if (side_q[1].neg && (side_q[1].sector != SecRed)) begin
      num_h_d = num_h_d + NumW'(delta_q) - NumW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      num_h_q <= num_h_d;
      num_s_q <= NumW'({delta_q, {SatFracW{1'b0}}});
      den_h_q <= delta_q;
      den_s_q <= side_q[1].brightness;
    end
  end

  // stages 3..6: |diff|*3840/delta (rounded up where noted) and delta*32768/max
  logic [QuoW-1:0] quo_h, quo_s;

  r2h_div u_div_hue (
    .clk_i (clk_i),
    .en_i  (en[DivFirst +: DivStages]),
    .num_i (num_h_q),
    .den_i (den_h_q),
    .quo_o (quo_h)
  );

  r2h_div u_div_sat (
    .clk_i (clk_i),
    .en_i  (en[DivFirst +: DivStages]),
    .num_i (num_s_q),
    .den_i (den_s_q),
    .quo_o (quo_s)
  );

  // output stage: add sector offset, wrap negative hue, zero gray pixels
  side_t                side_o;
  logic [HueW-1:0]      hue_d, hue_q;
  logic [SatW-1:0]      sat_q;
  logic [ChanW-1:0]     bright_q;

  assign side_o = side_q[OutStg-1];

  always_comb begin
    logic signed [SatW-1:0] base;
    logic signed [SatW-1:0] hq;
    case (side_o.sector)
      SecRed:   base = '0;
      SecGreen: base = SatW'(2 * HueScale);
      SecBlue:  base = SatW'(4 * HueScale);
      default:  base = '0;
    endcase
    if (side_o.neg) begin
      hq = base - signed'(quo_h);
    end else begin
      hq = base + signed'(quo_h);
    end
    if (hq < 0) begin
      hq = hq + SatW'(HueFull);
    end
    hue_d = side_o.gray ? '0 : hq[HueW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[OutStg]) begin
      hue_q    <= hue_d;
      sat_q    <= side_o.gray ? '0 : quo_s;
      bright_q <= side_o.brightness;
    end
  end

  assign valid_o      = v_q[OutStg];
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;

endmodule
